// ===== rtl/pic_pkg.sv =====
// pic_pkg: shared types, constants and clip helper for the PI controller.
// Used by every module of pi_controller_saturating; depends on nothing.

package pic_pkg;

    localparam int unsigned SHIFT_BITS = 8;
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned WIDE_W     = 32;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned INDEX_W    = 3;

    typedef enum logic [INDEX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_MODE_TAG    = 3'd3,
        REG_INTEG_LIMIT = 3'd4,
        REG_CLIP_LOW    = 3'd5,
        REG_CLIP_HIGH   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  setpoint;
        logic signed [DATA_W-1:0]  prop_gain;
        logic signed [DATA_W-1:0]  integ_gain;
        logic signed [WIDE_W-1:0]  mode_tag;
        logic        [LIMIT_W-1:0] integ_limit;
        logic signed [DATA_W-1:0]  clip_low;
        logic signed [DATA_W-1:0]  clip_high;
    } cfg_t;

    // with inverted bounds, inputs below the low bound give the low bound, all others the high bound
    function automatic logic signed [DATA_W-1:0] clip16(
        input logic signed [32:0]       x,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [32:0] lo_w;
        logic signed [32:0] hi_w;
        logic signed [DATA_W-1:0] res;
        lo_w = 33'(lo);
        hi_w = 33'(hi);
        if (x < lo_w)
            res = lo;
        else if (x > hi_w)
            res = hi;
        else
            res = x[DATA_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/pi_controller_saturating.sv =====
// pi_controller_saturating: top level of the PI controller with integrator clamp.
// Depends on pic_pkg, pic_cfg_regs, pic_integ_stage and pic_drive_stage.
//
// Usage:
//   s_axis carries one measured sample per beat (tdata[15:0] = sample, signed).
//   m_axis carries one drive value per sample (tdata[15:0] = drive, signed).
//   Registers are written through wr_en / wr_index / wr_data while the
//   pipeline is empty: 0 setpoint, 1 prop_gain, 2 integ_gain, 3 mode_tag,
//   4 integ_limit, 5 clip_low, 6 clip_high; other indexes are ignored.
// Timing:
//   Five register stages: input, error clip, integrator update, multiply,
//   output. One beat per cycle sustained while m_axis_tready stays high; the
//   integrator add-and-clamp is combinational into its register, so
//   back-to-back samples update it in order.
// Reset:
//   Pipeline empties, integrator and last mode go to zero, bounds go to the
//   full 16-bit range, other registers to zero.
// Stall:
//   Each stage holds while its successor is full and stalled; s_axis_tready
//   drops only once all five stages hold beats.

module pi_controller_saturating (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data
);

    pic_pkg::cfg_t                      cfg;
    logic                               mid_valid;
    logic                               mid_ready;
    logic signed [pic_pkg::DATA_W-1:0]  mid_err;
    logic signed [pic_pkg::WIDE_W-1:0]  mid_integ;
    logic signed [pic_pkg::DATA_W-1:0]  drive;

    pic_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    pic_integ_stage u_integ (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample ($signed(s_axis_tdata)),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_err   (mid_err),
        .out_integ (mid_integ)
    );

    pic_drive_stage u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_err    (mid_err),
        .in_integ  (mid_integ),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_drive (drive)
    );

    assign m_axis_tdata = drive;

endmodule

// ===== rtl/pic_cfg_regs.sv =====
// pic_cfg_regs: configuration register file, written through a plain write port.
// Depends on pic_pkg.

module pic_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [pic_pkg::INDEX_W-1:0]     wr_index,
    input  logic [pic_pkg::WIDE_W-1:0]      wr_data,
    output pic_pkg::cfg_t                   cfg
);

    pic_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint    <= '0;
            cfg_reg.prop_gain   <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.mode_tag    <= '0;
            cfg_reg.integ_limit <= '0;
            cfg_reg.clip_low    <= 16'sh8000;
            cfg_reg.clip_high   <= 16'sh7FFF;
        end
        else if (wr_en)
        begin
            unique case (pic_pkg::reg_index_t'(wr_index))
                pic_pkg::REG_SETPOINT:    cfg_reg.setpoint    <= wr_data[15:0];
                pic_pkg::REG_PROP_GAIN:   cfg_reg.prop_gain   <= wr_data[15:0];
                pic_pkg::REG_INTEG_GAIN:  cfg_reg.integ_gain  <= wr_data[15:0];
                pic_pkg::REG_MODE_TAG:    cfg_reg.mode_tag    <= wr_data;
                pic_pkg::REG_INTEG_LIMIT: cfg_reg.integ_limit <= wr_data[30:0];
                pic_pkg::REG_CLIP_LOW:    cfg_reg.clip_low    <= wr_data[15:0];
                pic_pkg::REG_CLIP_HIGH:   cfg_reg.clip_high   <= wr_data[15:0];
                default:                  ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pic_integ_stage.sv =====
// pic_integ_stage: input register, error clip, and the integrator with its clamp.
// Depends on pic_pkg.

module pic_integ_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pic_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pic_pkg::DATA_W-1:0]  in_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pic_pkg::DATA_W-1:0]  out_err,
    output logic signed [pic_pkg::WIDE_W-1:0]  out_integ
);

    logic                               a_valid_reg;
    logic signed [pic_pkg::DATA_W-1:0]  a_sample_reg;
    logic                               b_valid_reg;
    logic signed [pic_pkg::DATA_W-1:0]  b_err_reg;
    logic                               c_valid_reg;
    logic signed [pic_pkg::DATA_W-1:0]  c_err_reg;
    logic signed [pic_pkg::WIDE_W-1:0]  c_integ_reg;
    logic signed [pic_pkg::WIDE_W-1:0]  integrator_reg;
    logic signed [pic_pkg::WIDE_W-1:0]  last_mode_reg;

    logic                               c_ready;
    logic                               b_ready;
    logic                               load_a;
    logic                               load_b;
    logic                               load_c;
    logic signed [16:0]                 diff;
    logic signed [pic_pkg::DATA_W-1:0]  err_next;
    logic signed [pic_pkg::WIDE_W-1:0]  prev;
    logic signed [32:0]                 sum;
    logic signed [32:0]                 lim_pos;
    logic signed [32:0]                 lim_neg;
    logic signed [pic_pkg::WIDE_W-1:0]  integ_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign load_a   = in_valid && in_ready;
    assign load_b   = a_valid_reg && b_ready;
    assign load_c   = b_valid_reg && c_ready;

    always_comb
    begin
        diff     = 17'(cfg.setpoint) - 17'(a_sample_reg);
        err_next = pic_pkg::clip16(33'(diff), cfg.clip_low, cfg.clip_high);
    end

    always_comb
    begin
        prev    = (cfg.mode_tag != last_mode_reg) ? '0 : integrator_reg;
        sum     = 33'(b_err_reg) + 33'(prev);
        lim_pos = $signed({2'b00, cfg.integ_limit});
        lim_neg = -lim_pos;
        if (sum < lim_neg)
            integ_next = lim_neg[31:0];
        else if (sum > lim_pos)
            integ_next = lim_pos[31:0];
        else
            integ_next = sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            integrator_reg <= '0;
            last_mode_reg  <= '0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (load_c)
            begin
                integrator_reg <= integ_next;
                last_mode_reg  <= cfg.mode_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
            a_sample_reg <= in_sample;
        if (load_b)
            b_err_reg <= err_next;
        if (load_c)
        begin
            c_err_reg   <= b_err_reg;
            c_integ_reg <= integ_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_err   = c_err_reg;
    assign out_integ = c_integ_reg;

endmodule

// ===== rtl/pic_drive_stage.sv =====
// pic_drive_stage: gain multiplies, then sum, shift and clip into the output register.
// Depends on pic_pkg.

module pic_drive_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pic_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pic_pkg::DATA_W-1:0]  in_err,
    input  logic signed [pic_pkg::WIDE_W-1:0]  in_integ,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pic_pkg::DATA_W-1:0]  out_drive
);

    logic                               d_valid_reg;
    logic signed [31:0]                 d_pprod_reg;
    logic signed [47:0]                 d_iprod_reg;
    logic                               e_valid_reg;
    logic signed [pic_pkg::DATA_W-1:0]  e_drive_reg;

    logic                               e_ready;
    logic                               load_d;
    logic                               load_e;
    logic signed [31:0]                 pprod_next;
    logic signed [47:0]                 iprod_next;
    logic signed [47:0]                 iprod_sh;
    logic signed [40:0]                 acc;
    logic signed [40:0]                 acc_sh;
    logic signed [pic_pkg::DATA_W-1:0]  drive_next;

    assign e_ready  = !e_valid_reg || out_ready;
    assign in_ready = !d_valid_reg || e_ready;
    assign load_d   = in_valid && in_ready;
    assign load_e   = d_valid_reg && e_ready;

    always_comb
    begin
        pprod_next = 32'(in_err) * 32'(cfg.prop_gain);
        iprod_next = 48'(in_integ) * 48'(cfg.integ_gain);
    end

    always_comb
    begin
        iprod_sh   = d_iprod_reg >>> pic_pkg::SHIFT_BITS;
        acc        = 41'(d_pprod_reg) + 41'(iprod_sh);
        acc_sh     = acc >>> pic_pkg::SHIFT_BITS;
        drive_next = pic_pkg::clip16(acc_sh[32:0], cfg.clip_low, cfg.clip_high);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                d_valid_reg <= in_valid;
            if (e_ready)
                e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_d)
        begin
            d_pprod_reg <= pprod_next;
            d_iprod_reg <= iprod_next;
        end
        if (load_e)
            e_drive_reg <= drive_next;
    end

    assign out_valid = e_valid_reg;
    assign out_drive = e_drive_reg;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for pi_controller_saturating.
// Needs pic_pkg and the controller RTL; a clocked driver and monitor move stream
// beats, and a predictor of the error clip, integrator clamp and drive tracks results.

module tb_top;

    localparam logic [pic_pkg::INDEX_W-1:0] REG_UNUSED  = 3'd7;
    localparam int unsigned                 CYCLE_LIMIT = 300000;
    localparam int unsigned                 STALL_LEN   = 200;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        wr_en         = 1'b0;
    logic [2:0]  wr_index      = '0;
    logic [31:0] wr_data       = '0;

    // predictor copy of the registers and state
    logic signed [pic_pkg::DATA_W-1:0]  set_pt    = '0;
    logic signed [pic_pkg::DATA_W-1:0]  kp        = '0;
    logic signed [pic_pkg::DATA_W-1:0]  ki        = '0;
    logic signed [pic_pkg::WIDE_W-1:0]  mode_cfg  = '0;
    logic        [pic_pkg::LIMIT_W-1:0] integ_lim = '0;
    logic signed [pic_pkg::DATA_W-1:0]  clip_lo   = 16'sh8000;
    logic signed [pic_pkg::DATA_W-1:0]  clip_hi   = 16'sh7FFF;
    logic signed [pic_pkg::WIDE_W-1:0]  integ_acc = '0;
    logic signed [pic_pkg::WIDE_W-1:0]  mode_seen = '0;

    logic [15:0] sample_q[$];
    logic [15:0] drive_exp_q[$];

    int unsigned send_wait        = 0;
    int unsigned recv_wait        = 0;
    int unsigned recv_next        = 0;
    int unsigned send_gap_max     = 0;
    int unsigned recv_gap_max     = 0;
    int unsigned stall_left       = 0;
    logic        stall_req        = 1'b0;
    int unsigned cycle_count      = 0;
    int unsigned err_count        = 0;
    int unsigned samples_accepted = 0;
    int unsigned beats_checked    = 0;
    int unsigned settings_count   = 0;

    pi_controller_saturating dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [15:0] sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [15:0] drive
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [pic_pkg::DATA_W-1:0] bound_to_clip(longint x);
        if (x < clip_lo)
            return clip_lo;
        if (x > clip_hi)
            return clip_hi;
        return 16'(x);
    endfunction

    function automatic void predict_drive(logic [15:0] raw);
        longint smp;
        longint err;
        longint prev;
        longint sum;
        longint lim;
        longint acc;
        smp  = longint'($signed(raw));
        err  = bound_to_clip(longint'(set_pt) - smp);
        prev = (mode_cfg != mode_seen) ? 0 : longint'(integ_acc);
        lim  = longint'(integ_lim);
        sum  = err + prev;
        if (sum < -lim)
            sum = -lim;
        else if (sum > lim)
            sum = lim;
        acc = longint'(kp) * err + ((longint'(ki) * sum) >>> pic_pkg::SHIFT_BITS);
        integ_acc = 32'(sum);
        mode_seen = mode_cfg;
        drive_exp_q.push_back(bound_to_clip(acc >>> pic_pkg::SHIFT_BITS));
    endfunction

    task automatic report_error(string msg);
        err_count++;
        $display("ERROR @%0d: %0s", cycle_count, msg);
    endtask

    task automatic check_drive(logic [15:0] got);
        logic [15:0] want;
        beats_checked++;
        if (drive_exp_q.size() == 0)
            report_error($sformatf("drive %0d with no sample pending", $signed(got)));
        else
        begin
            want = drive_exp_q.pop_front();
            if (got !== want)
                report_error($sformatf("drive got %0d expected %0d",
                                       $signed(got), $signed(want)));
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_wait     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_drive(s_axis_tdata);
                samples_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_wait != 0)
                begin
                    send_wait     <= send_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_q.pop_front();
                    send_wait     <= $urandom_range(0, send_gap_max);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
        end
        else
        begin
            recv_next = recv_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_drive(m_axis_tdata);
                recv_next = $urandom_range(0, recv_gap_max);
            end
            else if (recv_next != 0)
                recv_next = recv_next - 1;
            recv_wait     <= recv_next;
            m_axis_tready <= (recv_next == 0) && (stall_left == 0);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (stall_req)
            stall_left <= STALL_LEN;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(logic [pic_pkg::INDEX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            pic_pkg::REG_SETPOINT:    set_pt    = val[15:0];
            pic_pkg::REG_PROP_GAIN:   kp        = val[15:0];
            pic_pkg::REG_INTEG_GAIN:  ki        = val[15:0];
            pic_pkg::REG_MODE_TAG:    mode_cfg  = val;
            pic_pkg::REG_INTEG_LIMIT: integ_lim = val[30:0];
            pic_pkg::REG_CLIP_LOW:    clip_lo   = val[15:0];
            pic_pkg::REG_CLIP_HIGH:   clip_hi   = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_settings(logic [31:0] sp, logic [31:0] p, logic [31:0] i,
                                 logic [31:0] md, logic [31:0] lim,
                                 logic [31:0] lo, logic [31:0] hi);
        write_reg(pic_pkg::REG_SETPOINT, sp);
        write_reg(pic_pkg::REG_PROP_GAIN, p);
        write_reg(pic_pkg::REG_INTEG_GAIN, i);
        write_reg(pic_pkg::REG_MODE_TAG, md);
        write_reg(pic_pkg::REG_INTEG_LIMIT, lim);
        write_reg(pic_pkg::REG_CLIP_LOW, lo);
        write_reg(pic_pkg::REG_CLIP_HIGH, hi);
        settings_count++;
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || s_axis_tvalid || drive_exp_q.size() != 0)
            @(negedge clk);
    endtask

    // upper half random: the block must ignore it for 16-bit registers
    function automatic logic [31:0] pick_word16();
        logic [31:0] r;
        logic [15:0] low;
        r = $urandom;
        case ($urandom_range(0, 6))
            0: low = 16'h8000;
            1: low = 16'h7FFF;
            2: low = 16'h0000;
            3: low = 16'($urandom_range(0, 600)) - 16'd300;
            4: low = 16'($urandom_range(0, 1024));
            default: low = 16'($urandom);
        endcase
        return {r[31:16], low};
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000 | 32'($urandom_range(0, 4000));
            3: return 32'($urandom_range(0, 4000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mode();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom);
            4, 5: return set_pt + 16'($urandom_range(0, 127)) - 16'd64;
            default: return set_pt + 16'($urandom_range(0, 4095)) - 16'd2048;
        endcase
    endfunction

    task automatic random_settings();
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] r;
        a = 16'($urandom);
        b = 16'($urandom);
        r = $urandom;
        case ($urandom_range(0, 4))
            0:
            begin
                a = 16'h8000;
                b = 16'h7FFF;
            end
            1:
            begin
                if ($signed(a) > $signed(b))
                begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
            end
            2:
            begin
                if ($signed(a) < $signed(b))
                begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
            end
            3:
                b = a;
            default:
            begin
                a = -16'($urandom_range(0, 2000));
                b = 16'($urandom_range(0, 2000));
            end
        endcase
        load_settings(pick_word16(), pick_word16(), pick_word16(),
                      ($urandom_range(0, 1) != 0) ? mode_cfg : pick_mode(),
                      pick_limit(), {r[31:16], a}, {r[15:0], b});
    endtask

    task automatic send_batch(int unsigned n);
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
        recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
        repeat (n)
            sample_q.push_back(pick_sample());
        wait_idle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero gains, full bounds
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'hFFFF);
        wait_idle();

        // largest gains and limit, mode change clears the integrator
        load_settings(32'h0000_0000, 32'h0000_7FFF, 32'h0000_7FFF, 32'd5,
                      32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0000_7FFF);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'd12345);
        wait_idle();

        // most negative gains, zero limit, inverted bounds
        load_settings(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'h8000_0000,
                      32'h0000_0000, 32'd100, 32'hFFFF_FF9C);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'd50);
        sample_q.push_back(16'd150);
        wait_idle();

        // write to an unused index must change nothing
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        load_settings(32'h0000_7FFF, 32'd256, 32'd1024, 32'h7FFF_FFFF,
                      32'd1000, 32'hFFFF_FE0C, 32'd500);
        write_reg(REG_UNUSED, 32'h0000_0000);
        sample_q.push_back(16'h8000);
        sample_q.push_back(16'h5555);
        sample_q.push_back(16'hAAAA);
        sample_q.push_back(16'h7FFF);
        sample_q.push_back(16'd100);
        sample_q.push_back(16'd100);
        wait_idle();

        repeat (12)
        begin
            random_settings();
            send_batch(52);
            write_reg(pic_pkg::REG_MODE_TAG,
                      ($urandom_range(0, 1) != 0) ? mode_cfg : pick_mode());
            send_batch(52);
        end

        // receiver holds off while the sender keeps offering beats
        random_settings();
        send_gap_max = 0;
        recv_gap_max = 0;
        @(posedge clk);
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
        repeat (40)
            sample_q.push_back(pick_sample());
        wait_idle();

        repeat (20) @(posedge clk);
        if (drive_exp_q.size() != 0)
            report_error($sformatf("%0d drive beats never arrived", drive_exp_q.size()));
        $display("run covered %0d samples and %0d drive beats over %0d register settings",
                 samples_accepted, beats_checked, settings_count);
        $display("including inverted bounds, zero and full integrator limits, mode changes");
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
